// ===== sv/lrs_pkg.sv =====
// Shared types and constants of the five-point Laplacian residual block.
// Depends on nothing; every other file of the block imports it.
package lrs_pkg;

   localparam int DATA_W  = 32;
   localparam int LEN_W   = 6;
   localparam int CNT_W   = 12;
   localparam int SCALE_W = 12;
   localparam int ACC_W   = 35;
   localparam int PROD_W  = 48;

   localparam logic [LEN_W-1:0] GRID_LEN_RESET = LEN_W'(33);
   localparam logic [LEN_W-1:0] MIN_LEN        = LEN_W'(2);

   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sh0000_0000_8000_0000);

   typedef logic signed [DATA_W-1:0] data_type;

   // Geometry that follows from the side length.
   typedef struct packed {
      logic [LEN_W-1:0]   side;
      logic [SCALE_W-1:0] scale;
      logic [CNT_W-1:0]   last;
      logic [CNT_W-1:0]   last_flush;
   } geom_type;

   // One stencil window handed from the line buffers to the arithmetic.
   typedef struct packed {
      data_type         center;
      data_type         left;
      data_type         right;
      data_type         up;
      data_type         down;
      data_type         rhs;
      logic             has_left;
      logic             has_right;
      logic             has_up;
      logic             has_down;
      logic [CNT_W-1:0] index;
      logic             last;
   } tap_type;

endpackage

// ===== sv/lrs_req_if.sv =====
// Input channel of the residual block: one grid cell per transfer.
// Depends on lrs_pkg.
interface lrs_req_if;
   import lrs_pkg::*;

   logic     valid;
   logic     ready;
   data_type u_value;
   data_type rhs_value;

   modport source (output valid, output u_value, output rhs_value, input ready);
   modport sink (input valid, input u_value, input rhs_value, output ready);
endinterface

// ===== sv/lrs_rsp_if.sv =====
// Result channel of the residual block: one residual per transfer.
// Depends on lrs_pkg.
interface lrs_rsp_if;
   import lrs_pkg::*;

   logic             valid;
   logic             ready;
   data_type         residual;
   logic [CNT_W-1:0] cell_index;
   logic             last_of_grid;

   modport source (output valid, output residual, output cell_index, output last_of_grid,
                   input ready);
   modport sink (input valid, input residual, input cell_index, input last_of_grid,
                 output ready);
endinterface

// ===== sv/lrs_cell.sv =====
// One storage cell of a line buffer: loads the new value when it is the
// entry point of the line, else its upstream neighbor. Depends on lrs_pkg.
module lrs_cell (
   input  logic             clock,
   input  logic             shift,
   input  logic             entry,
   input  lrs_pkg::data_type new_data,
   input  lrs_pkg::data_type next_data,
   output lrs_pkg::data_type data
);
   import lrs_pkg::*;

   data_type data_ff;
   data_type data_in;

   always_comb begin
      data_in = entry ? new_data : next_data;
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

// ===== sv/lrs_line.sv =====
// Variable-length line buffer built as a row of lrs_cell instances.
// Depends on lrs_pkg and lrs_cell.
module lrs_line #(
   parameter int DEPTH = 63
) (
   input  logic             clock,
   input  logic             shift,
   input  logic [DEPTH-1:0] entry,
   input  lrs_pkg::data_type new_data,
   output lrs_pkg::data_type head,
   output lrs_pkg::data_type second
);
   import lrs_pkg::*;

   data_type cell_q [DEPTH];

   // Data moves toward index 0; the head is the oldest value in the line.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type next_data;
      if (i == DEPTH - 1) begin : g_top
         assign next_data = new_data;
      end else begin : g_mid
         assign next_data = cell_q[i+1];
      end
      lrs_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .entry     (entry[i]),
         .new_data  (new_data),
         .next_data (next_data),
         .data      (cell_q[i])
      );
   end

   assign head   = cell_q[0];
   assign second = cell_q[1];

endmodule

// ===== sv/lrs_arith.sv =====
// Four-stage residual pipeline: window register, neighbor sum, scale
// multiply, subtract with saturation. Depends on lrs_pkg and lrs_rsp_if.
module lrs_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lrs_pkg::SCALE_W-1:0]   scale,
   input  logic                          tap_valid,
   output logic                          tap_ready,
   input  lrs_pkg::tap_type              tap,
   lrs_rsp_if.source                     rsp_ch
);
   import lrs_pkg::*;

   logic valid_t_ff, valid_a_ff, valid_m_ff, valid_o_ff;
   logic en_t, en_a, en_m, en_o;

   tap_type                   tap_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   data_type                  rhs_a_ff, rhs_m_ff;
   logic [CNT_W-1:0]          idx_a_ff, idx_m_ff, idx_o_ff;
   logic                      last_a_ff, last_m_ff, last_o_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  scale_x, acc_x, diff;
   data_type                  res_ff, res_in;

   // A stage moves on when it is empty or the next stage moves on.
   always_comb begin
      en_o      = !valid_o_ff || rsp_ch.ready;
      en_m      = !valid_m_ff || en_o;
      en_a      = !valid_a_ff || en_m;
      en_t      = !valid_t_ff || en_a;
      tap_ready = en_t;
   end

   always_comb begin
      acc_in = -(ACC_W'(tap_ff.center) <<< 2);
      if (tap_ff.has_left) begin
         acc_in = acc_in + ACC_W'(tap_ff.left);
      end
      if (tap_ff.has_right) begin
         acc_in = acc_in + ACC_W'(tap_ff.right);
      end
      if (tap_ff.has_up) begin
         acc_in = acc_in + ACC_W'(tap_ff.up);
      end
      if (tap_ff.has_down) begin
         acc_in = acc_in + ACC_W'(tap_ff.down);
      end
   end

   always_comb begin
      scale_x = PROD_W'(signed'({1'b0, scale}));
      acc_x   = PROD_W'(acc_ff);
      prod_in = scale_x * acc_x;
   end

   always_comb begin
      diff = PROD_W'(rhs_m_ff) - prod_ff;
      if (diff > SAT_MAX) begin
         res_in = DATA_W'(SAT_MAX);
      end else if (diff < SAT_MIN) begin
         res_in = DATA_W'(SAT_MIN);
      end else begin
         res_in = DATA_W'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_t_ff <= 1'b0;
         valid_a_ff <= 1'b0;
         valid_m_ff <= 1'b0;
         valid_o_ff <= 1'b0;
      end else begin
         if (en_t) begin
            valid_t_ff <= tap_valid;
         end
         if (en_a) begin
            valid_a_ff <= valid_t_ff;
         end
         if (en_m) begin
            valid_m_ff <= valid_a_ff;
         end
         if (en_o) begin
            valid_o_ff <= valid_m_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_t) begin
         tap_ff <= tap;
      end
      if (en_a) begin
         acc_ff    <= acc_in;
         rhs_a_ff  <= tap_ff.rhs;
         idx_a_ff  <= tap_ff.index;
         last_a_ff <= tap_ff.last;
      end
      if (en_m) begin
         prod_ff   <= prod_in;
         rhs_m_ff  <= rhs_a_ff;
         idx_m_ff  <= idx_a_ff;
         last_m_ff <= last_a_ff;
      end
      if (en_o) begin
         res_ff    <= res_in;
         idx_o_ff  <= idx_m_ff;
         last_o_ff <= last_m_ff;
      end
   end

   assign rsp_ch.valid        = valid_o_ff;
   assign rsp_ch.residual     = res_ff;
   assign rsp_ch.cell_index   = idx_o_ff;
   assign rsp_ch.last_of_grid = last_o_ff;

endmodule

// ===== sv/laplacian_residual_stencil.sv =====
// Top level of the five-point Laplacian residual block.
// Depends on lrs_pkg, lrs_req_if, lrs_rsp_if, lrs_line and lrs_arith.
//
// The block takes one grid cell per transfer on req_ch, in row-major order,
// and returns d = b - (n-1)^2 * (u_left + u_right + u_up + u_down - 4*u) on
// rsp_ch for every cell, with the cell index, a flag on the final cell and the
// result saturated to 32 bits. Neighbors across a row edge or outside the grid
// are left out. The side length n comes from csr_wr_data (values below two act
// as two, values above MAX_GRID_LEN as MAX_GRID_LEN); a write also starts a new
// grid. Three line buffers, each a row of cells of MAX_GRID_LEN entries whose
// entry point is set by n, hold the last 2n solution values and the last n
// right-hand sides. One cell is accepted every clock cycle unless rsp_ch
// stalls or a grid drains. The window of cell k is formed at the transfer of
// cell k+n; after the final cell of a grid the block holds req_ch.ready low
// while it pushes the last row out of the line buffers. A stall on rsp_ch
// fills the four pipeline stages before req_ch.ready drops.
module laplacian_residual_stencil #(
   parameter int MAX_GRID_LEN = 63
) (
   input  logic                       clock,
   input  logic                       reset,
   lrs_req_if.sink                    req_ch,
   lrs_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [lrs_pkg::LEN_W-1:0]  csr_wr_data
);
   import lrs_pkg::*;

   // Side length clamp and the quantities that follow from it.
   function automatic geom_type geom_of(input logic [LEN_W-1:0] len);
      geom_type           g;
      logic [SCALE_W-1:0] side_m1;
      logic [CNT_W-1:0]   side_w;
      g.side = len;
      if (len < MIN_LEN) begin
         g.side = MIN_LEN;
      end else if (len > LEN_W'(MAX_GRID_LEN)) begin
         g.side = LEN_W'(MAX_GRID_LEN);
      end
      side_m1      = SCALE_W'(g.side) - SCALE_W'(1);
      side_w       = CNT_W'(g.side);
      g.scale      = side_m1 * side_m1;
      g.last       = side_w * side_w - CNT_W'(1);
      g.last_flush = g.last + side_w;
      return g;
   endfunction

   localparam geom_type GEOM_RESET = geom_of(GRID_LEN_RESET);

   geom_type          geom_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  col_ff, col_in;
   logic [LEN_W-1:0]  row_ff, row_in;
   data_type          left_ff;

   logic [LEN_W-1:0]        side_m1;
   logic [MAX_GRID_LEN-1:0] entry;
   logic                    flushing;
   logic                    tap_ready;
   logic                    accept;
   logic                    step;
   logic                    emit;
   data_type                u_head, u_second, up_head, rhs_head;
   tap_type                 tap;

   assign side_m1 = geom_ff.side - LEN_W'(1);

   // The cell at index n-1 is where each line takes new data, so a value
   // leaves the head of the line exactly n shifts after it went in.
   always_comb begin
      for (int i = 0; i < MAX_GRID_LEN; i++) begin
         entry[i] = (LEN_W'(i) == side_m1);
      end
   end

   // Past the final cell the counter keeps running for n more steps; those
   // steps take no input and only drain the last row out of the lines.
   assign flushing     = (cnt_ff > geom_ff.last);
   assign req_ch.ready = !flushing && tap_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign step         = accept || (flushing && tap_ready);
   assign emit         = step && (cnt_ff >= CNT_W'(geom_ff.side));

   // Solution values: line a holds u[k-1..k-n], line b holds u[k-n-1..k-2n].
   lrs_line #(.DEPTH(MAX_GRID_LEN)) u_line_near (
      .clock    (clock),
      .shift    (step),
      .entry    (entry),
      .new_data (req_ch.u_value),
      .head     (u_head),
      .second   (u_second)
   );

   lrs_line #(.DEPTH(MAX_GRID_LEN)) u_line_far (
      .clock    (clock),
      .shift    (step),
      .entry    (entry),
      .new_data (u_head),
      .head     (up_head),
      .second   ()
   );

   lrs_line #(.DEPTH(MAX_GRID_LEN)) u_line_rhs (
      .clock    (clock),
      .shift    (step),
      .entry    (entry),
      .new_data (req_ch.rhs_value),
      .head     (rhs_head),
      .second   ()
   );

   // During the drain the incoming u is no neighbor: the cells drained sit in
   // the bottom row, so the down term is masked off there anyway.
   always_comb begin
      tap.center    = u_head;
      tap.left      = left_ff;
      tap.right     = u_second;
      tap.up        = up_head;
      tap.down      = req_ch.u_value;
      tap.rhs       = rhs_head;
      tap.has_left  = (col_ff != '0);
      tap.has_right = (col_ff != side_m1);
      tap.has_up    = (row_ff != '0);
      tap.has_down  = (row_ff != side_m1);
      tap.index     = cnt_ff - CNT_W'(geom_ff.side);
      tap.last      = (col_ff == side_m1) && (row_ff == side_m1);
   end

   always_comb begin
      cnt_in = (cnt_ff == geom_ff.last_flush) ? '0 : cnt_ff + CNT_W'(1);
      col_in = col_ff + LEN_W'(1);
      row_in = row_ff;
      if (col_ff == side_m1) begin
         col_in = '0;
         row_in = (row_ff == side_m1) ? '0 : row_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= GEOM_RESET;
         cnt_ff  <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (csr_wr_en) begin
         geom_ff <= geom_of(csr_wr_data);
         cnt_ff  <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         if (step) begin
            cnt_ff <= cnt_in;
         end
         if (emit) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // The value that leaves line a is the left neighbor of the next center.
   always_ff @(posedge clock) begin
      if (step) begin
         left_ff <= u_head;
      end
   end

   lrs_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .scale     (geom_ff.scale),
      .tap_valid (emit),
      .tap_ready (tap_ready),
      .tap       (tap),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== sv/lrs_checker.sv =====
// Port-level checks of the residual block and the bind that attaches them.
// Depends on lrs_pkg and laplacian_residual_stencil.
module lrs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input lrs_pkg::data_type          residual,
   input logic [lrs_pkg::CNT_W-1:0]  cell_index,
   input logic                       last_of_grid,
   input logic                       csr_wr_en
);
   import lrs_pkg::*;

   logic [CNT_W-1:0] expect_idx_ff;
   logic             rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // Residuals of a grid come out in cell order and restart after the last.
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         expect_idx_ff <= '0;
      end else if (rsp_xfer) begin
         expect_idx_ff <= last_of_grid ? '0 : cell_index + CNT_W'(1);
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(residual) && $stable(cell_index)
         && $stable(last_of_grid))
      else $error("result withdrawn or changed while stalled");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> cell_index == expect_idx_ff)
      else $error("residual out of cell order");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && last_of_grid |-> cell_index != '0)
      else $error("grid end flagged on the first cell");

endmodule

bind laplacian_residual_stencil lrs_checker u_lrs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .residual     (rsp_ch.residual),
   .cell_index   (rsp_ch.cell_index),
   .last_of_grid (rsp_ch.last_of_grid),
   .csr_wr_en    (csr_wr_en)
);
